[design/fpcr_pkg.sv]
// Shared types, codes and the CRC-32 byte update for the packet receiver.
`timescale 1ns / 1ps

package fpcr_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [7:0]  START_BYTE_RST = 8'h02;
  localparam logic [7:0]  END_BYTE_RST   = 8'h03;
  localparam logic [15:0] MAX_LEN_RST    = 16'd4096;
  localparam logic [31:0] CRC_INIT_RST   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_START_BYTE = 2'd0,
    REG_END_BYTE   = 2'd1,
    REG_MAX_LEN    = 2'd2,
    REG_CRC_INIT   = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    K_CONSOLE = 3'd0,
    K_HEADER  = 3'd1,
    K_PAYLOAD = 3'd2,
    K_TRAILER = 3'd3,
    K_GOOD    = 3'd4,
    K_LENERR  = 3'd5,
    K_CRCERR  = 3'd6,
    K_ETXERR  = 3'd7
  } kind_t;

  typedef struct packed {
    logic [31:0] crc_init;
    logic [15:0] max_len;
    logic [7:0]  end_byte;
    logic [7:0]  start_byte;
  } cfg_t;

  typedef struct packed {
    logic [15:0] payload_length;
    logic [7:0]  command_code;
    logic [15:0] seq_number;
    logic [7:0]  slave_address;
    logic [7:0]  byte_value;
    kind_t       kind;
  } result_t;

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[design/fpcr_parser.sv]
// Packet parser: phase sequencer, running CRC and held header fields.
`timescale 1ns / 1ps

module fpcr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  fpcr_pkg::cfg_t   cfg,
  output fpcr_pkg::result_t result
);

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_SLAVE  = 4'd1,
    PH_NUM_LO = 4'd2,
    PH_NUM_HI = 4'd3,
    PH_CMD    = 4'd4,
    PH_LEN_LO = 4'd5,
    PH_LEN_HI = 4'd6,
    PH_DATA   = 4'd7,
    PH_CRC    = 4'd8,
    PH_END    = 4'd9
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] crc_running_r, crc_running_nxt;
  logic [31:0] crc_final_r, crc_final_nxt;
  logic [31:0] crc_received_r, crc_received_nxt;
  logic [1:0]  trailer_index_r, trailer_index_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]  held_slave_r, held_slave_nxt;
  logic [15:0] held_number_r, held_number_nxt;
  logic [7:0]  held_command_r, held_command_nxt;
  logic [15:0] held_length_r, held_length_nxt;
  logic [31:0] crc_upd;
  logic [15:0] left_dec;
  fpcr_pkg::kind_t kind;
  logic        console;

  assign crc_upd  = fpcr_pkg::crc_byte(crc_running_r, rx_byte);
  assign left_dec = bytes_left_r - 16'd1;

  always_comb begin
    phase_nxt         = phase_r;
    crc_running_nxt   = crc_running_r;
    crc_final_nxt     = crc_final_r;
    crc_received_nxt  = crc_received_r;
    trailer_index_nxt = trailer_index_r;
    bytes_left_nxt    = bytes_left_r;
    held_slave_nxt    = held_slave_r;
    held_number_nxt   = held_number_r;
    held_command_nxt  = held_command_r;
    held_length_nxt   = held_length_r;
    kind              = fpcr_pkg::K_HEADER;
    console           = 1'b0;
    case (phase_r)
      PH_SLAVE: begin
        crc_running_nxt = crc_upd;
        held_slave_nxt  = rx_byte;
        phase_nxt       = PH_NUM_LO;
      end
      PH_NUM_LO: begin
        crc_running_nxt = crc_upd;
        held_number_nxt = {8'd0, rx_byte};
        phase_nxt       = PH_NUM_HI;
      end
      PH_NUM_HI: begin
        crc_running_nxt = crc_upd;
        held_number_nxt = {rx_byte, held_number_r[7:0]};
        phase_nxt       = PH_CMD;
      end
      PH_CMD: begin
        crc_running_nxt  = crc_upd;
        held_command_nxt = rx_byte;
        phase_nxt        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        crc_running_nxt = crc_upd;
        held_length_nxt = {8'd0, rx_byte};
        phase_nxt       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        crc_running_nxt   = crc_upd;
        held_length_nxt   = {rx_byte, held_length_r[7:0]};
        trailer_index_nxt = 2'd0;
        crc_received_nxt  = 32'd0;
        if (held_length_nxt > cfg.max_len) begin
          kind      = fpcr_pkg::K_LENERR;
          phase_nxt = PH_HUNT;
        end else if (held_length_nxt == 16'd0) begin
          // empty payload: trailer follows at once
          crc_final_nxt = crc_upd ^ cfg.crc_init;
          phase_nxt     = PH_CRC;
        end else begin
          bytes_left_nxt = held_length_nxt;
          phase_nxt      = PH_DATA;
        end
      end
      PH_DATA: begin
        kind            = fpcr_pkg::K_PAYLOAD;
        crc_running_nxt = crc_upd;
        bytes_left_nxt  = left_dec;
        if (left_dec == 16'd0) begin
          crc_final_nxt = crc_upd ^ cfg.crc_init;
          phase_nxt     = PH_CRC;
        end
      end
      PH_CRC: begin
        kind = fpcr_pkg::K_TRAILER;
        crc_received_nxt[{trailer_index_r, 3'b000} +: 8] =
          crc_received_r[{trailer_index_r, 3'b000} +: 8] | rx_byte;
        trailer_index_nxt = trailer_index_r + 2'd1;
        if (trailer_index_r == 2'd3) begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        if (rx_byte != cfg.end_byte) begin
          kind = fpcr_pkg::K_ETXERR;
        end else if (crc_final_r != crc_received_r) begin
          kind = fpcr_pkg::K_CRCERR;
        end else begin
          kind = fpcr_pkg::K_GOOD;
        end
        phase_nxt = PH_HUNT;
      end
      default: begin
        // hunting, and any unused phase code
        if (rx_byte == cfg.start_byte) begin
          held_slave_nxt    = 8'd0;
          held_number_nxt   = 16'd0;
          held_command_nxt  = 8'd0;
          held_length_nxt   = 16'd0;
          crc_received_nxt  = 32'd0;
          trailer_index_nxt = 2'd0;
          bytes_left_nxt    = 16'd0;
          crc_running_nxt   = fpcr_pkg::crc_byte(cfg.crc_init, rx_byte);
          phase_nxt         = PH_SLAVE;
        end else begin
          phase_nxt = PH_HUNT;
          kind      = fpcr_pkg::K_CONSOLE;
          console   = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    result.kind           = kind;
    result.byte_value     = rx_byte;
    result.slave_address  = console ? 8'd0  : held_slave_nxt;
    result.seq_number     = console ? 16'd0 : held_number_nxt;
    result.command_code   = console ? 8'd0  : held_command_nxt;
    result.payload_length = console ? 16'd0 : held_length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HUNT;
      crc_running_r   <= fpcr_pkg::CRC_INIT_RST;
      crc_final_r     <= 32'd0;
      crc_received_r  <= 32'd0;
      trailer_index_r <= 2'd0;
      bytes_left_r    <= 16'd0;
      held_slave_r    <= 8'd0;
      held_number_r   <= 16'd0;
      held_command_r  <= 8'd0;
      held_length_r   <= 16'd0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      crc_running_r   <= crc_running_nxt;
      crc_final_r     <= crc_final_nxt;
      crc_received_r  <= crc_received_nxt;
      trailer_index_r <= trailer_index_nxt;
      bytes_left_r    <= bytes_left_nxt;
      held_slave_r    <= held_slave_nxt;
      held_number_r   <= held_number_nxt;
      held_command_r  <= held_command_nxt;
      held_length_r   <= held_length_nxt;
    end
  end

endmodule

[design/framed_packet_crc32_receiver_unit.sv]
// Top level: config registers, input register, parser and result register.
//
//  channel | direction | transfer carries
//  in_     | slave     | one received byte
//  out_    | master    | one result: kind in tuser, byte and header fields in tdata
//  cfg_    | write     | one register write, no wait
//
// One byte per cycle sustained while the output is not stalled. The parser steps when the
// input register moves into the result register, so the CRC byte update and phase step lie
// on the combinational path between the two registers.
// rst_n is synchronous: phase to hunting, all but the payload registers to their reset values.
// A stalled output holds its result; one more byte waits in the input register.
`timescale 1ns / 1ps

module framed_packet_crc32_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // byte_value, slave_address, seq_number,
                                  // command_code, payload_length
  output logic [2:0]  out_tuser,  // [2:0] kind
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  fpcr_pkg::cfg_t    cfg_r;
  fpcr_pkg::result_t res;
  fpcr_pkg::result_t out_res_r;
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  logic        advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  fpcr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= fpcr_pkg::START_BYTE_RST;
      cfg_r.end_byte   <= fpcr_pkg::END_BYTE_RST;
      cfg_r.max_len    <= fpcr_pkg::MAX_LEN_RST;
      cfg_r.crc_init   <= fpcr_pkg::CRC_INIT_RST;
    end else if (cfg_wr_en) begin
      case (fpcr_pkg::reg_index_t'(cfg_index))
        fpcr_pkg::REG_START_BYTE: cfg_r.start_byte <= cfg_wdata[7:0];
        fpcr_pkg::REG_END_BYTE:   cfg_r.end_byte   <= cfg_wdata[7:0];
        fpcr_pkg::REG_MAX_LEN:    cfg_r.max_len    <= cfg_wdata[15:0];
        fpcr_pkg::REG_CRC_INIT:   cfg_r.crc_init   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {out_res_r.payload_length, out_res_r.command_code,
                       out_res_r.seq_number, out_res_r.slave_address,
                       out_res_r.byte_value};

endmodule

[tb/framed_packet_crc32_receiver_unit_test.sv]
// Self-checking testbench: deframer bytes in, per-byte results checked against a local model.
`timescale 1ns / 1ps

module framed_packet_crc32_receiver_unit_test;
  import fpcr_pkg::*;

  localparam int          IDLE_LIMIT  = 1000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          PRINT_CAP   = 60;
  localparam logic [31:0] POLY_REFL   = 32'hEDB8_8320;

  typedef enum logic [3:0] {
    RX_HUNT, RX_SLAVE, RX_NUM_LO, RX_NUM_HI, RX_CMD,
    RX_LEN_LO, RX_LEN_HI, RX_DATA, RX_CRC, RX_END
  } rx_phase_t;

  typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PATTERN} ready_mode_t;

  // directed row: expected result typed in only where fixed is set
  typedef struct {
    logic [7:0]  rx;
    bit          fixed;
    kind_t       kind;
    logic [7:0]  slave;
    logic [15:0] num;
    logic [7:0]  cmd;
    logic [15:0] len;
  } row_t;

  typedef struct {
    logic [7:0] rx;
    bit         fixed;
    result_t    want;
  } rx_item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;           // byte_value, slave_address, seq_number,
                                    // command_code, payload_length
  logic [2:0]  out_tuser;           // [2:0] kind
  logic        cfg_wr_en  = 1'b0;
  logic [1:0]  cfg_index  = 2'd0;
  logic [31:0] cfg_wdata  = 32'h0;

  framed_packet_crc32_receiver_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // register mirror
  logic [7:0]  sb       = START_BYTE_RST;
  logic [7:0]  eb       = END_BYTE_RST;
  logic [15:0] max_len  = MAX_LEN_RST;
  logic [31:0] crc_seed = CRC_INIT_RST;

  // parser mirror
  rx_phase_t   rx_ph   = RX_HUNT;
  logic [31:0] crc_run = CRC_INIT_RST;
  logic [31:0] crc_fin = 32'h0;
  logic [31:0] crc_rx  = 32'h0;
  logic [1:0]  t_idx   = 2'd0;
  logic [15:0] left    = 16'h0;
  logic [7:0]  h_slave = 8'h0;
  logic [15:0] h_num   = 16'h0;
  logic [7:0]  h_cmd   = 8'h0;
  logic [15:0] h_len   = 16'h0;

  rx_item_t byte_q[$];
  result_t  result_q[$];

  int  queued_total = 0;
  int  bytes_in     = 0;
  int  results_out  = 0;
  int  errors       = 0;
  int  quiet        = 0;
  int  kind_count[8];
  bit  took_in      = 1'b0;
  bit  hold_req     = 1'b0;

  row_t dir_tab [22] = '{
    '{8'h00, 1'b1, K_CONSOLE, 8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'hFF, 1'b1, K_CONSOLE, 8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h03, 1'b1, K_CONSOLE, 8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h02, 1'b1, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    // start byte value reused as slave id inside the packet
    '{8'h02, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h34, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h12, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'hA5, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h01, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    // 0x1001 is one over the reset maximum
    '{8'h10, 1'b1, K_LENERR,  8'h02, 16'h1234, 8'hA5, 16'h1001},
    '{8'h02, 1'b1, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h00, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h00, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h00, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h00, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h00, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    // zero length: trailer straight after the header
    '{8'h00, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'hFF, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h00, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h80, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h01, 1'b0, K_HEADER,  8'h00, 16'h0000, 8'h00, 16'h0000},
    '{8'h55, 1'b1, K_ETXERR,  8'h00, 16'h0000, 8'h00, 16'h0000}
  };

  function automatic logic [31:0] crc32_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[31:1]} ^ ((r[0] ^ b[k]) ? POLY_REFL : 32'h0);
    end
    return r;
  endfunction

  // steps the parser mirror by one byte and returns the result it causes
  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t r;
    bit      console;
    r.kind  = K_HEADER;
    console = 1'b0;
    case (rx_ph)
      RX_SLAVE: begin
        crc_run = crc32_fold(crc_run, b);
        h_slave = b;
        rx_ph   = RX_NUM_LO;
      end
      RX_NUM_LO: begin
        crc_run = crc32_fold(crc_run, b);
        h_num   = {8'h00, b};
        rx_ph   = RX_NUM_HI;
      end
      RX_NUM_HI: begin
        crc_run = crc32_fold(crc_run, b);
        h_num   = {b, h_num[7:0]};
        rx_ph   = RX_CMD;
      end
      RX_CMD: begin
        crc_run = crc32_fold(crc_run, b);
        h_cmd   = b;
        rx_ph   = RX_LEN_LO;
      end
      RX_LEN_LO: begin
        crc_run = crc32_fold(crc_run, b);
        h_len   = {8'h00, b};
        rx_ph   = RX_LEN_HI;
      end
      RX_LEN_HI: begin
        crc_run = crc32_fold(crc_run, b);
        h_len   = {b, h_len[7:0]};
        t_idx   = 2'd0;
        crc_rx  = 32'h0;
        if (h_len > max_len) begin
          r.kind = K_LENERR;
          rx_ph  = RX_HUNT;
        end else if (h_len == 16'h0) begin
          crc_fin = crc_run ^ crc_seed;
          rx_ph   = RX_CRC;
        end else begin
          left  = h_len;
          rx_ph = RX_DATA;
        end
      end
      RX_DATA: begin
        r.kind  = K_PAYLOAD;
        crc_run = crc32_fold(crc_run, b);
        left    = left - 16'd1;
        if (left == 16'h0) begin
          crc_fin = crc_run ^ crc_seed;
          rx_ph   = RX_CRC;
        end
      end
      RX_CRC: begin
        r.kind = K_TRAILER;
        crc_rx[8*t_idx +: 8] = b;
        if (t_idx == 2'd3) begin
          t_idx = 2'd0;
          rx_ph = RX_END;
        end else begin
          t_idx = t_idx + 2'd1;
        end
      end
      RX_END: begin
        if (b != eb) begin
          r.kind = K_ETXERR;
        end else if (crc_fin != crc_rx) begin
          r.kind = K_CRCERR;
        end else begin
          r.kind = K_GOOD;
        end
        rx_ph = RX_HUNT;
      end
      default: begin
        if (b == sb) begin
          h_slave = 8'h0;
          h_num   = 16'h0;
          h_cmd   = 8'h0;
          h_len   = 16'h0;
          crc_rx  = 32'h0;
          t_idx   = 2'd0;
          left    = 16'h0;
          crc_run = crc32_fold(crc_seed, b);
          rx_ph   = RX_SLAVE;
        end else begin
          r.kind  = K_CONSOLE;
          console = 1'b1;
          rx_ph   = RX_HUNT;
        end
      end
    endcase
    r.byte_value     = b;
    r.slave_address  = console ? 8'h0  : h_slave;
    r.seq_number     = console ? 16'h0 : h_num;
    r.command_code   = console ? 8'h0  : h_cmd;
    r.payload_length = console ? 16'h0 : h_len;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("%0t: result %0d %s mismatch: got %0h, want %0h",
               $realtime, results_out, field, got, want);
    end
  endtask

  task automatic check_result(input result_t got, input result_t want);
    if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
    if (got.byte_value !== want.byte_value)
      report_mismatch("byte_value", 32'(got.byte_value), 32'(want.byte_value));
    if (got.slave_address !== want.slave_address)
      report_mismatch("slave_address", 32'(got.slave_address), 32'(want.slave_address));
    if (got.seq_number !== want.seq_number)
      report_mismatch("seq_number", 32'(got.seq_number), 32'(want.seq_number));
    if (got.command_code !== want.command_code)
      report_mismatch("command_code", 32'(got.command_code), 32'(want.command_code));
    if (got.payload_length !== want.payload_length)
      report_mismatch("payload_length", 32'(got.payload_length), 32'(want.payload_length));
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_item_t it;
    it.rx    = b;
    it.fixed = 1'b0;
    it.want  = '0;
    byte_q.push_back(it);
    queued_total++;
  endtask

  // a whole frame built with the current register values; header stops at the
  // length when the length is over the maximum
  task automatic queue_packet(input int len, input bit bad_crc, input bit bad_end);
    logic [31:0] c;
    logic [7:0]  hdr [6];
    logic [7:0]  d;
    hdr[0] = 8'($urandom);
    hdr[1] = 8'($urandom);
    hdr[2] = 8'($urandom);
    hdr[3] = 8'($urandom);
    hdr[4] = len[7:0];
    hdr[5] = len[15:8];
    push_byte(sb);
    c = crc32_fold(crc_seed, sb);
    for (int i = 0; i < 6; i++) begin
      push_byte(hdr[i]);
      c = crc32_fold(c, hdr[i]);
    end
    if (len > int'(max_len)) return;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      push_byte(d);
      c = crc32_fold(c, d);
    end
    c = c ^ crc_seed;
    if (bad_crc) c = c ^ (32'h1 << $urandom_range(0, 31));
    for (int k = 0; k < 4; k++) push_byte(c[8*k +: 8]);
    push_byte(bad_end ? (eb ^ 8'($urandom_range(1, 255))) : eb);
  endtask

  task automatic fill_phase(input int n);
    int          target;
    int          pick;
    int          cap;
    int          len;
    logic [7:0]  b;
    target = queued_total + n;
    cap    = int'(max_len);
    while (queued_total < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        repeat ($urandom_range(1, 6)) begin
          b = 8'($urandom);
          if (b == sb) b = b ^ 8'h01;
          push_byte(b);
        end
      end else if (pick < 22 && cap < 65535) begin
        queue_packet($urandom_range(cap + 1, 65535), 1'b0, 1'b0);
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          len = $urandom_range(0, (cap < 12) ? cap : 12);
        end else begin
          len = (cap <= 80) ? cap : $urandom_range(12, 80);
        end
        queue_packet(len, $urandom_range(0, 9) == 0, $urandom_range(0, 14) == 0);
      end
    end
  endtask

  task automatic load_regs(input logic [7:0] s, input logic [7:0] e,
                           input logic [15:0] m, input logic [31:0] ci);
    logic [31:0] vals [4];
    vals[REG_START_BYTE] = {24'h0, s};
    vals[REG_END_BYTE]   = {24'h0, e};
    vals[REG_MAX_LEN]    = {16'h0, m};
    vals[REG_CRC_INIT]   = ci;
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    sb       = s;
    eb       = e;
    max_len  = m;
    crc_seed = ci;
  endtask

  // no new bytes are queued until every byte is sent and every result is in
  task automatic settle();
    while (byte_q.size() != 0 || result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // transfer monitor and scoreboard
  always @(posedge clk) begin : monitor
    rx_item_t it;
    result_t  seen;
    result_t  guess;
    took_in = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen = result_t'({out_tdata, out_tuser});
        results_out++;
        kind_count[out_tuser]++;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result, kind", 32'(seen.kind), 32'h0);
        end else begin
          check_result(seen, result_q.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        it    = byte_q.pop_front();
        guess = deframe_byte(it.rx);
        result_q.push_back(it.fixed ? it.want : guess);
        took_in = 1'b1;
        bytes_in++;
      end
    end
  end

  // sender: bursts with random gaps; never drops valid before the transfer
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin : sender
    logic       nv;
    logic [7:0] nd;
    nv = in_tvalid;
    nd = in_tdata;
    if (rst_n && !(in_tvalid && !took_in)) begin
      if (took_in && burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        nv = 1'b0;
        gap_left--;
      end else begin
        nv = (byte_q.size() != 0);
        if (nv) nd = byte_q[0].rx;
      end
    end
    in_tvalid <= nv;
    in_tdata  <= nd;
  end

  // receiver: stall pattern switches every so often, plus one long hold-off
  ready_mode_t rdy_mode  = RDY_ALWAYS;
  int          mode_left = 0;
  int          hold_left = 0;
  int          pat_cnt   = 0;

  always @(negedge clk) begin : receiver
    logic r;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (mode_left == 0) begin
      rdy_mode  = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 200);
    end
    mode_left--;
    pat_cnt++;
    case (rdy_mode)
      RDY_ALWAYS: r = 1'b1;
      RDY_HALF:   r = 1'($urandom_range(0, 1));
      RDY_SPARSE: r = ($urandom_range(0, 3) == 0);
      default:    r = (pat_cnt % 5 != 4) && (pat_cnt % 7 != 0);
    endcase
    if (hold_left > 0) begin
      r = 1'b0;
      hold_left--;
    end
    out_tready <= r;
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet, result_q.size());
        $display("framed_packet_crc32_receiver_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rx_item_t it;
    foreach (kind_count[k]) kind_count[k] = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset register values: directed frames, then random traffic
    foreach (dir_tab[i]) begin
      it.rx    = dir_tab[i].rx;
      it.fixed = dir_tab[i].fixed;
      it.want  = '{payload_length: dir_tab[i].len, command_code: dir_tab[i].cmd,
                   seq_number: dir_tab[i].num, slave_address: dir_tab[i].slave,
                   byte_value: dir_tab[i].rx, kind: dir_tab[i].kind};
      byte_q.push_back(it);
      queued_total++;
    end
    fill_phase(350);
    settle();

    // zero maximum: every non-empty frame is a length error
    load_regs(8'h00, 8'hFF, 16'h0000, 32'h0000_0000);
    fill_phase(370);
    settle();

    load_regs(8'hFF, 8'h00, 16'hFFFF, 32'hFFFF_FFFF);
    fill_phase(370);
    hold_req = 1'b1;
    settle();

    load_regs(8'($urandom), 8'($urandom), 16'($urandom_range(16, 80)), $urandom);
    fill_phase(370);
    settle();

    load_regs(START_BYTE_RST, END_BYTE_RST, MAX_LEN_RST, CRC_INIT_RST);
    fill_phase(370);
    settle();
    repeat (8) @(negedge clk);

    $display("%0d bytes over five register settings, %0d results checked, %0d mismatches",
             bytes_in, results_out, errors);
    $display("frames: %0d good, %0d length, %0d checksum, %0d end-byte errors; %0d console",
             kind_count[K_GOOD], kind_count[K_LENERR], kind_count[K_CRCERR],
             kind_count[K_ETXERR], kind_count[K_CONSOLE]);
    if (errors == 0 && result_q.size() == 0) begin
      $display("framed_packet_crc32_receiver_unit regression: pass");
    end else begin
      $display("framed_packet_crc32_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule
